@@ design/peak_normalizer_macros.svh @@
// ----------------------------------------------------------------------------
// peak_normalizer_macros.svh
// Assertion macros shared by the peak normalizer modules.
// ----------------------------------------------------------------------------
`ifndef PEAK_NORMALIZER_MACROS_SVH
`define PEAK_NORMALIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset
`define PN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("peak_normalizer: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define PN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("peak_normalizer: next-cycle check failed");

`else

`define PN_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ design/pn_pkg.sv @@
// ----------------------------------------------------------------------------
// pn_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pn_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int SAMPLE_W  = 16;

    // Commands from controller to datapath
    typedef struct packed {
        logic store;      // write accepted sample, update peak and count
        logic drop;       // buffer full: flag the lost sample
        logic first;      // rewind read index
        logic rd;         // read buffer entry into the data register
        logic div_start;  // start the serial divider
        logic load;       // load the output register
        logic next;       // advance read index
        logic clear;      // end of block: clear count, peak and drop flag
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic full;       // buffer holds DEPTH samples
        logic is_last;    // read index points at the final stored sample
        logic div_done;   // quotient ready
        logic div_busy;   // divider iterating
        logic out_free;   // output register can take a beat
    } t_stat;

endpackage

@@ design/peak_normalizer.sv @@
// ----------------------------------------------------------------------------
// peak_normalizer
// Block peak normalization of signed 16-bit samples to Q1.15.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_ready    | i_sample, i_last
//   out     | output    | o_out_valid / i_out_ready  | o_scaled, o_final_res,
//           |           |                            | o_zero_peak, o_overflowed
//
// Samples are taken one a cycle while a block is collected. After the beat
// marked last, input stalls and each stored sample steps through buffer
// read, divider load, 16 divider steps, done and output load, which waits
// while the output is stalled.
// Input reopens once the final beat sits in the output register.
// Reset is synchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module peak_normalizer #(
    parameter int DEPTH = pn_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pn_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pn_pkg::SAMPLE_W-1:0]   o_scaled,
    output logic                          o_final_res,
    output logic                          o_zero_peak,
    output logic                          o_overflowed
);

    pn_pkg::t_cmd  w_cmd;
    pn_pkg::t_stat w_stat;

    pn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_last),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pn_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_sample     (i_sample),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_scaled     (o_scaled),
        .o_final_res  (o_final_res),
        .o_zero_peak  (o_zero_peak),
        .o_overflowed (o_overflowed)
    );

endmodule

@@ design/pn_div.sv @@
// ----------------------------------------------------------------------------
// pn_div
// Restoring serial divider: floor(dividend * 2^15 / divisor), one bit a cycle.
// The dividend never exceeds the divisor, so the quotient fits 16 bits.
// ----------------------------------------------------------------------------
`include "peak_normalizer_macros.svh"

module pn_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pn_pkg::SAMPLE_W-1:0]   i_dividend,
    input  logic [pn_pkg::SAMPLE_W-1:0]   i_divisor,
    output logic [pn_pkg::SAMPLE_W-1:0]   o_quotient,
    output logic                          o_done,
    output logic                          o_busy
);

    localparam int W  = pn_pkg::SAMPLE_W;
    localparam int NW = $clog2(W);

    logic [W:0]    r_rem;
    logic [W:0]    n_rem;
    logic [W-1:0]  r_quo;
    logic [NW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          w_ge;
    logic [W:0]    w_diff;

    // Trial subtract for the current bit
    always_comb begin
        w_ge   = r_rem >= {1'b0, i_divisor};
        w_diff = w_ge ? (r_rem - {1'b0, i_divisor}) : r_rem;
        n_rem  = {w_diff[W-1:0], 1'b0};
    end

    // Control: count steps, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + NW'(1);
                if (r_cnt == NW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift remainder, collect quotient bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend};
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[W-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;
    assign o_busy     = r_busy;

    `PN_ASSERT_NOW(a_div_start_idle, i_clk, i_rst_n, i_start, !r_busy)

endmodule

@@ design/pn_dp.sv @@
// ----------------------------------------------------------------------------
// pn_dp
// Datapath: sample buffer, fill count, peak tracker, divider and output stage.
// ----------------------------------------------------------------------------
`include "peak_normalizer_macros.svh"

module pn_dp #(
    parameter int DEPTH = pn_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pn_pkg::t_cmd                  i_cmd,
    output pn_pkg::t_stat                 o_stat,
    input  logic [pn_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [pn_pkg::SAMPLE_W-1:0]   o_scaled,
    output logic                          o_final_res,
    output logic                          o_zero_peak,
    output logic                          o_overflowed
);

    localparam int W  = pn_pkg::SAMPLE_W;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Two's complement magnitude; the most negative value maps to 2^(W-1)
    function automatic logic [W-1:0] mag_of(input logic [W-1:0] s);
        mag_of = s[W-1] ? (~s + W'(1)) : s;
    endfunction

    logic [W-1:0]  mem [DEPTH];
    logic [CW-1:0] r_fill;
    logic [W-1:0]  r_peak;
    logic          r_drop;
    logic [AW-1:0] r_rd_idx;
    logic [W-1:0]  r_rd_data;
    logic [W-1:0]  w_in_mag;
    logic [W-1:0]  w_quo;
    logic          w_div_done;
    logic          w_div_busy;
    logic [W-1:0]  n_scaled;
    logic          w_last;
    logic          w_out_free;

    logic          r_out_valid;
    logic [W-1:0]  r_scaled;
    logic          r_final;
    logic          r_zero_peak;
    logic          r_ovf;

    assign w_in_mag   = mag_of(i_sample);
    assign w_last     = (CW'(r_rd_idx) + CW'(1)) == r_fill;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Buffer: write at fill count, registered read at read index
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[r_fill[AW-1:0]] <= i_sample;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_rd_idx];
        end
    end

    // Block state: count, peak, drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_peak <= '0;
            r_drop <= 1'b0;
        end else if (i_cmd.clear) begin
            r_fill <= '0;
            r_peak <= '0;
            r_drop <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                r_fill <= r_fill + CW'(1);
                if (w_in_mag > r_peak) begin
                    r_peak <= w_in_mag;
                end
            end
            if (i_cmd.drop) begin
                r_drop <= 1'b1;
            end
        end
    end

    // Read index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (i_cmd.first) begin
            r_rd_idx <= '0;
        end else if (i_cmd.next) begin
            r_rd_idx <= r_rd_idx + AW'(1);
        end
    end

    pn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (mag_of(r_rd_data)),
        .i_divisor  (r_peak),
        .o_quotient (w_quo),
        .o_done     (w_div_done),
        .o_busy     (w_div_busy)
    );

    // Apply sign, saturate +1.0, force zero for an all-zero block
    always_comb begin
        if (r_peak == '0) begin
            n_scaled = '0;
        end else if (r_rd_data[W-1]) begin
            n_scaled = ~w_quo + W'(1);
        end else if (w_quo[W-1]) begin
            n_scaled = {1'b0, {(W-1){1'b1}}};
        end else begin
            n_scaled = w_quo;
        end
    end

    // Output register: hold beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_scaled    <= n_scaled;
            r_final     <= w_last;
            r_zero_peak <= (r_peak == '0);
            r_ovf       <= r_drop;
        end
    end

    assign o_stat.full     = (r_fill == CW'(DEPTH));
    assign o_stat.is_last  = w_last;
    assign o_stat.div_done = w_div_done;
    assign o_stat.div_busy = w_div_busy;
    assign o_stat.out_free = w_out_free;

    assign o_out_valid  = r_out_valid;
    assign o_scaled     = r_scaled;
    assign o_final_res  = r_final;
    assign o_zero_peak  = r_zero_peak;
    assign o_overflowed = r_ovf;

    `PN_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CW'(DEPTH))
    `PN_ASSERT_NOW(a_load_free, i_clk, i_rst_n, i_cmd.load, w_out_free)
    `PN_ASSERT_NOW(a_store_room, i_clk, i_rst_n, i_cmd.store, r_fill < CW'(DEPTH))

endmodule

@@ design/pn_ctrl.sv @@
// ----------------------------------------------------------------------------
// pn_ctrl
// Controller: collects a block, then steps read, divide and output per sample.
// ----------------------------------------------------------------------------
`include "peak_normalizer_macros.svh"

module pn_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_last,
    output logic           o_in_ready,
    input  pn_pkg::t_stat  i_stat,
    output pn_pkg::t_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_COLLECT = 5'b00001,
        S_READ    = 5'b00010,
        S_START   = 5'b00100,
        S_DIV     = 5'b01000,
        S_OUT     = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    assign o_in_ready = (r_state == S_COLLECT);
    assign w_acc      = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_COLLECT: begin
                if (w_acc) begin
                    o_cmd.store = !i_stat.full;
                    o_cmd.drop  = i_stat.full;
                    if (i_last) begin
                        o_cmd.first = 1'b1;
                        n_state     = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_START;
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.is_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_COLLECT;
                    end else begin
                        o_cmd.next = 1'b1;
                        n_state    = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    `PN_ASSERT_NOW(a_collect_div_idle, i_clk, i_rst_n, r_state == S_COLLECT, !i_stat.div_busy)

endmodule

@@ dv/pn_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn_checker
// Watches both channels of the peak normalizer. Each input beat feeds its own
// copy of the block buffer, peak and drop flag. The beat marked last turns the
// block into a list of expected Q1.15 beats. Every output beat is compared
// field by field with the oldest one on that list.
// ----------------------------------------------------------------------------
module pn_checker #(
    parameter int DEPTH = pn_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [pn_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                          i_last,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [pn_pkg::SAMPLE_W-1:0]   i_scaled,
    input  logic                          i_final_res,
    input  logic                          i_zero_peak,
    input  logic                          i_overflowed,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct {
        logic [pn_pkg::SAMPLE_W-1:0] scaled;
        logic                        final_res;
        logic                        zero_peak;
        logic                        overflowed;
    } t_norm_beat;

    t_norm_beat                  due_beats[$];
    logic [pn_pkg::SAMPLE_W-1:0] block_buf [DEPTH];
    int unsigned                 block_fill;
    logic [16:0]                 block_peak;
    logic                        block_dropped;
    int                          fails;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fails        = 0;
    end

    // Magnitude of a two's complement sample; the most negative one gives 32768
    function automatic logic [16:0] magnitude(input logic [15:0] raw);
        if (raw[15]) begin
            return 17'h10000 - {1'b0, raw};
        end
        return {1'b0, raw};
    endfunction

    // Sample over peak in Q1.15: divide magnitudes, truncate, then put the sign back, saturating +1.0
    function automatic logic [15:0] q15_ratio(input logic [15:0] raw, input logic [16:0] peak);
        logic [31:0] quot;
        logic [16:0] neg;
        if (peak == 17'd0) begin
            return 16'd0;
        end
        quot = ({15'd0, magnitude(raw)} << 15) / {15'd0, peak};
        if (quot > 32'd32768) begin
            quot = 32'd32768;
        end
        if (raw[15]) begin
            neg = 17'h10000 - quot[16:0];
            return neg[15:0];
        end
        if (quot > 32'd32767) begin
            quot = 32'd32767;
        end
        return quot[15:0];
    endfunction

    always @(posedge i_clk) begin
        t_norm_beat  want;
        t_norm_beat  fresh;
        logic [16:0] mag;
        if (!i_rst_n) begin
            due_beats.delete();
            block_fill    = 0;
            block_peak    = '0;
            block_dropped = 1'b0;
        end else begin
            // Compare an output beat with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (due_beats.size() == 0) begin
                    $error("pn_checker: output beat with nothing expected, scaled %0d",
                           $signed(i_scaled));
                    fails++;
                end else begin
                    want = due_beats.pop_front();
                    if (i_scaled !== want.scaled) begin
                        $error("pn_checker: scaled expected %0d, got %0d",
                               $signed(want.scaled), $signed(i_scaled));
                        fails++;
                    end
                    if (i_final_res !== want.final_res) begin
                        $error("pn_checker: final_res expected %0b, got %0b",
                               want.final_res, i_final_res);
                        fails++;
                    end
                    if (i_zero_peak !== want.zero_peak) begin
                        $error("pn_checker: zero_peak expected %0b, got %0b",
                               want.zero_peak, i_zero_peak);
                        fails++;
                    end
                    if (i_overflowed !== want.overflowed) begin
                        $error("pn_checker: overflowed expected %0b, got %0b",
                               want.overflowed, i_overflowed);
                        fails++;
                    end
                end
            end

            // Store the input beat, or flag it when the buffer is full
            if (i_in_valid && i_in_ready) begin
                if (block_fill < DEPTH) begin
                    block_buf[block_fill] = i_sample;
                    block_fill++;
                    mag = magnitude(i_sample);
                    if (mag > block_peak) begin
                        block_peak = mag;
                    end
                end else begin
                    block_dropped = 1'b1;
                end

                // Close the block: queue one scaled beat per stored sample
                if (i_last) begin
                    for (int k = 0; k < block_fill; k++) begin
                        fresh.scaled     = q15_ratio(block_buf[k], block_peak);
                        fresh.final_res  = (k == block_fill - 1);
                        fresh.zero_peak  = (block_peak == 17'd0);
                        fresh.overflowed = block_dropped;
                        due_beats.push_back(fresh);
                    end
                    block_fill    = 0;
                    block_peak    = '0;
                    block_dropped = 1'b0;
                end
            end
        end
        o_pending    <= due_beats.size();
        o_fail_count <= fails;
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench top for the peak normalizer. Drives blocks of samples, each closed
// by a last beat: a directed opening of corner blocks, then random blocks of
// mostly small size with a few full and overflowing ones. Both sides idle in
// random bursts, the receiver holds off twice for a long stretch, and the tail
// of the run has no idling. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb;

    localparam int BUF_DEPTH   = pn_pkg::DEPTH_DEF;
    localparam int ITEM_BUDGET = 470;
    localparam int CALM_ITEMS  = 50;
    localparam int HOLD_CYCLES = 600;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN       = 60;

    typedef enum {FLAT_ZERO, FAINT, WIDE} t_blk_flavor;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [pn_pkg::SAMPLE_W-1:0] i_sample;
    logic                        i_last;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [pn_pkg::SAMPLE_W-1:0] o_scaled;
    logic                        o_final_res;
    logic                        o_zero_peak;
    logic                        o_overflowed;

    int fail_count;
    int pending_beats;
    int items_sent = 0;
    int gap_pct    = 0;
    int idle_run   = 0;
    bit calm_tail  = 1'b0;

    // Opening blocks as {last, sample}: full-scale peaks, most negative peak,
    // all-zero block, saturation at +1.0, small peak, alternating bit patterns
    logic [16:0] opening_beats [20] = '{
        {1'b1, 16'h7FFF},
        {1'b1, 16'h8000},
        {1'b0, 16'h0000}, {1'b0, 16'h0000}, {1'b1, 16'h0000},
        {1'b0, 16'h8000}, {1'b0, 16'h7FFF}, {1'b0, 16'hFFFF}, {1'b0, 16'h0001},
        {1'b1, 16'h0000},
        {1'b0, 16'h7FFF}, {1'b0, 16'h8001}, {1'b0, 16'h4000}, {1'b1, 16'hC000},
        {1'b0, 16'd100},  {1'b0, 16'hFFF9}, {1'b1, 16'd3},
        {1'b0, 16'h0000}, {1'b0, 16'h5555}, {1'b1, 16'hAAAA}
    };

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    peak_normalizer #(
        .DEPTH(BUF_DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_scaled     (o_scaled),
        .o_final_res  (o_final_res),
        .o_zero_peak  (o_zero_peak),
        .o_overflowed (o_overflowed)
    );

    pn_checker #(
        .DEPTH(BUF_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .i_last       (i_last),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_scaled     (o_scaled),
        .i_final_res  (o_final_res),
        .i_zero_peak  (o_zero_peak),
        .i_overflowed (o_overflowed),
        .o_fail_count (fail_count),
        .o_pending    (pending_beats)
    );

    // Offer one beat, after an optional idle burst, and hold it until taken
    task automatic push_sample(input logic [15:0] s, input logic l);
        if (!calm_tail && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        i_last     <= l;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        if (items_sent >= ITEM_BUDGET - CALM_ITEMS) begin
            calm_tail = 1'b1;
        end
    endtask

    function automatic logic [15:0] draw_sample(input t_blk_flavor flavor);
        logic [15:0] v;
        case (flavor)
            FLAT_ZERO: begin
                return 16'h0000;
            end
            FAINT: begin
                v = 16'($urandom_range(0, 64));
                return v - 16'd32;
            end
            default: begin
                if ($urandom_range(0, 9) != 0) begin
                    v = 16'($urandom);
                    return v;
                end
                case ($urandom_range(0, 5))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    2:       return 16'h8001;
                    3:       return 16'hFFFF;
                    4:       return 16'h0001;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    // Stimulus: reset, opening blocks, random blocks, then drain and verdict
    initial begin : stimulus
        int          blocks;
        int          len;
        int          pick;
        t_blk_flavor flavor;
        blocks     = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_sample   <= '0;
        i_last     <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_pct = 30;
        for (int k = 0; k < 20; k++) begin
            push_sample(opening_beats[k][15:0], opening_beats[k][16]);
        end

        while (items_sent < ITEM_BUDGET) begin
            blocks++;
            // Mostly short blocks; a few fill the buffer or run past it
            case (blocks)
                5:  len = BUF_DEPTH + 1;   // last beat lands on a full buffer
                12: len = BUF_DEPTH;
                20: len = BUF_DEPTH + 4;
                default: begin
                    pick = $urandom_range(0, 99);
                    if (pick < 2) begin
                        len = BUF_DEPTH + $urandom_range(1, 6);
                    end else if (pick < 15) begin
                        len = $urandom_range(9, 40);
                    end else begin
                        len = $urandom_range(1, 8);
                    end
                end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                flavor = FLAT_ZERO;
            end else if (pick < 20) begin
                flavor = FAINT;
            end else begin
                flavor = WIDE;
            end
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 35;
            endcase
            for (int k = 0; k < len; k++) begin
                push_sample(draw_sample(flavor), k == len - 1);
            end
        end

        // Drop valid and wait for the last block to come out
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0 && pending_beats == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Receiver: random stall bursts, and a long hold-off while beats pile up
    initial begin : sink
        int taken;
        int stall_pct;
        taken     = 0;
        stall_pct = 20;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                taken++;
                if (taken % 64 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       stall_pct = 0;
                        1:       stall_pct = 15;
                        default: stall_pct = 40;
                    endcase
                end
                if (!calm_tail && (taken == 30 || taken == 400)) begin
                    i_out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_run <= 0;
        end else if (idle_run == STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

endmodule
